// ===== hdl/sparse_block_delta_offset_decoder_defines.svh =====
// Assertion macros for the sparse block delta/offset decoder checker.
// Each macro expands to one labeled concurrent assertion on clk / arst_n.
`ifndef SPARSE_BLOCK_DELTA_OFFSET_DECODER_DEFINES_SVH
`define SPARSE_BLOCK_DELTA_OFFSET_DECODER_DEFINES_SVH

// Same-cycle implication
`define SBDO_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define SBDO_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/sbdo_pkg.sv =====
// Shared types, microcode ROM and arithmetic helpers for the sparse block decoder.
// Used by sbdo_seq, sbdo_dp and the top level; no dependencies.
package sbdo_pkg;

	localparam int BlockSize = 64;
	localparam int PosW      = $clog2(BlockSize) + 1;

	// token kinds, also the phase codes
	typedef enum logic [1:0] {
		CMD_HEADER = 2'd0,
		CMD_MASK1  = 2'd1,
		CMD_MASK2  = 2'd2,
		CMD_VALUE  = 2'd3
	} cmd_t;

	// result source
	typedef enum logic [1:0] {
		EM_NONE = 2'd0,
		EM_ERR  = 2'd1,
		EM_AMT  = 2'd2,
		EM_ZERO = 2'd3
	} em_t;

	// register update
	typedef enum logic [2:0] {
		RO_NONE = 3'd0,
		RO_HDR  = 3'd1,
		RO_M1   = 3'd2,
		RO_M2   = 3'd3,
		RO_END  = 3'd4
	} ro_t;

	// prefix mode decision
	typedef enum logic [1:0] {
		PF_NONE     = 2'd0,
		PF_OFS_ZERO = 2'd1,
		PF_AMT_EQ   = 2'd2
	} pf_t;

	// sequencing
	typedef enum logic [2:0] {
		J_NEXT     = 3'd0,
		J_GOTO     = 3'd1,
		J_DISPATCH = 3'd2,
		J_P0       = 3'd3,
		J_RUN      = 3'd4,
		J_WAIT_IN  = 3'd5
	} jmp_t;

	typedef logic [3:0] step_t;

	localparam step_t STEP_IDLE = 4'd0;
	localparam step_t STEP_DISP = 4'd1;
	localparam step_t STEP_ERR  = 4'd2;
	localparam step_t STEP_HDR  = 4'd3;  // HDR..VAL0 ordered by command code
	localparam step_t STEP_M1   = 4'd4;
	localparam step_t STEP_M2   = 4'd5;
	localparam step_t STEP_VAL0 = 4'd6;
	localparam step_t STEP_VAL1 = 4'd7;
	localparam step_t STEP_RUN  = 4'd8;
	localparam step_t STEP_CHK0 = 4'd9;
	localparam step_t STEP_PZ   = 4'd10;

	typedef struct packed {
		em_t   emit;
		ro_t   reg_op;
		pf_t   pfx_op;
		jmp_t  jmp;
		step_t target;
	} ctrl_t;

	// datapath status seen by the sequencer
	typedef struct packed {
		logic cmd_ok;
		cmd_t cmd;
		logic present;   // position under pos_q is set in the mask
		logic pos_end;   // all positions emitted
		logic out_free;  // output register can take a result
	} stat_t;

	// actions for the datapath this cycle
	typedef struct packed {
		logic fire;
		em_t  emit;
		ro_t  reg_op;
		pf_t  pfx_op;
	} act_t;

	// microprogram
	function automatic ctrl_t micro_rom(input step_t s);
		ctrl_t c;
		c = '{emit: EM_NONE, reg_op: RO_NONE, pfx_op: PF_NONE, jmp: J_GOTO,
			target: STEP_IDLE};
		unique case (s)
			STEP_IDLE: c.jmp = J_WAIT_IN;
			STEP_DISP: c.jmp = J_DISPATCH;
			STEP_ERR:  c.emit = EM_ERR;
			STEP_HDR:  c.reg_op = RO_HDR;
			STEP_M1:   c.reg_op = RO_M1;
			STEP_M2: begin
				c.reg_op = RO_M2;
				c.target = STEP_CHK0;
			end
			STEP_VAL0: begin
				c.pfx_op = PF_AMT_EQ;
				c.jmp    = J_NEXT;
			end
			STEP_VAL1: begin
				c.emit = EM_AMT;
				c.jmp  = J_NEXT;
			end
			STEP_RUN: begin
				c.emit   = EM_ZERO;
				c.reg_op = RO_END;
				c.jmp    = J_RUN;
			end
			STEP_CHK0: c.jmp = J_P0;
			STEP_PZ: begin
				c.pfx_op = PF_OFS_ZERO;
				c.target = STEP_RUN;
			end
			default: c.jmp = J_GOTO;
		endcase
		return c;
	endfunction

	// 33-bit sum clipped to signed 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
		logic signed [31:0] r;
		if (v[32] != v[31]) begin
			r = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

// ===== hdl/sparse_block_delta_offset_decoder.sv =====
// Sparse block delta/offset decoder, top level. A request is taken in the idle step
// and dispatched by command to the header, mask, value or error step. A dropped
// request's status result comes from the error step, a value's from its second step;
// a zero run follows a value, or a second mask when position 0 is absent. No new
// request is taken until the idle step returns; a run yields one sample per cycle,
// slowed only by output back-pressure. Reset (arst_n low) clears step, state, valid.
module sparse_block_delta_offset_decoder (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         command,
	input  logic signed [31:0] amount,
	input  logic [31:0]        mask_word,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] sample,
	output logic [5:0]         position,
	output logic               block_end,
	output logic               status
);

	sbdo_pkg::stat_t st;
	sbdo_pkg::act_t  act;

	sbdo_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.st       (st),
		.in_ready (in_ready),
		.act      (act)
	);

	sbdo_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_take   (in_valid && in_ready),
		.command   (command),
		.amount    (amount),
		.mask_word (mask_word),
		.act       (act),
		.st        (st),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sample    (sample),
		.position  (position),
		.block_end (block_end),
		.status    (status)
	);

endmodule

// ===== hdl/sbdo_seq.sv =====
// Microcode sequencer: step counter, control ROM and jump logic.
// Depends on sbdo_pkg.
module sbdo_seq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  sbdo_pkg::stat_t st,
	output logic           in_ready,
	output sbdo_pkg::act_t act
);

	sbdo_pkg::step_t step_q, step_d;
	sbdo_pkg::ctrl_t cw;
	logic            leave;
	logic            stall;
	sbdo_pkg::em_t   em;

	assign cw    = sbdo_pkg::micro_rom(step_q);
	assign leave = st.pos_end | st.present;

	// the run step emits only while it stays
	always_comb begin
		em = cw.emit;
		if (cw.jmp == sbdo_pkg::J_RUN && leave) begin
			em = sbdo_pkg::EM_NONE;
		end
	end

	assign stall = ((em != sbdo_pkg::EM_NONE) && !st.out_free) ||
		((cw.jmp == sbdo_pkg::J_WAIT_IN) && !in_valid);

	assign in_ready   = (step_q == sbdo_pkg::STEP_IDLE);
	assign act.fire   = !stall;
	assign act.emit   = em;
	assign act.reg_op = cw.reg_op;
	assign act.pfx_op = cw.pfx_op;

	// next step
	always_comb begin
		step_d = step_q;
		if (!stall) begin
			unique case (cw.jmp)
				sbdo_pkg::J_NEXT, sbdo_pkg::J_WAIT_IN: step_d = step_q + 4'd1;
				sbdo_pkg::J_GOTO: step_d = cw.target;
				sbdo_pkg::J_DISPATCH: begin
					step_d = st.cmd_ok ? 4'(sbdo_pkg::STEP_HDR + {2'b00, st.cmd})
						: sbdo_pkg::STEP_ERR;
				end
				sbdo_pkg::J_P0: step_d = st.present ? sbdo_pkg::STEP_IDLE : step_q + 4'd1;
				sbdo_pkg::J_RUN: step_d = leave ? cw.target : step_q;
				default: step_d = sbdo_pkg::STEP_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= sbdo_pkg::STEP_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

endmodule

// ===== hdl/sbdo_dp.sv =====
// Datapath: request latch, block state, saturating adder and output register.
// Depends on sbdo_pkg; driven by sbdo_seq actions.
module sbdo_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_take,
	input  logic [1:0]         command,
	input  logic signed [31:0] amount,
	input  logic [31:0]        mask_word,
	input  sbdo_pkg::act_t     act,
	output sbdo_pkg::stat_t    st,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] sample,
	output logic [5:0]         position,
	output logic               block_end,
	output logic               status
);

	// latched request
	sbdo_pkg::cmd_t     cmd_q;
	logic signed [31:0] amount_q;
	logic [31:0]        word_q;

	// block state
	sbdo_pkg::cmd_t                 phase_q;
	logic signed [31:0]             offset_q;
	logic [63:0]                    mask_q;
	logic [sbdo_pkg::PosW-1:0]      pos_q;
	logic signed [31:0]             sum_q;
	logic                           prefix_q;

	logic                           out_valid_q;
	logic signed [31:0]             t;
	logic signed [32:0]             raw;
	logic signed [31:0]             res;
	logic                           emit_val;

	always_ff @(posedge clk) begin
		if (in_take) begin
			cmd_q    <= sbdo_pkg::cmd_t'(command);
			amount_q <= amount;
			word_q   <= mask_word;
		end
	end

	// status to the sequencer; bit 63-p of the mask is position p
	assign st.cmd_ok   = (cmd_q == phase_q);
	assign st.cmd      = cmd_q;
	assign st.present  = mask_q[~pos_q[5:0]];
	assign st.pos_end  = pos_q[sbdo_pkg::PosW-1];
	assign st.out_free = !out_valid_q || out_ready;

	// one shared adder: running sum or header offset
	assign emit_val = act.fire &&
		(act.emit == sbdo_pkg::EM_AMT || act.emit == sbdo_pkg::EM_ZERO);
	assign t   = (act.emit == sbdo_pkg::EM_AMT) ? amount_q : 32'sd0;
	assign raw = prefix_q ? (33'(sum_q) + 33'(t)) : (33'(offset_q) + 33'(t));
	assign res = sbdo_pkg::sat32(raw);

	// block state updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= sbdo_pkg::CMD_HEADER;
			offset_q <= '0;
			mask_q   <= '0;
			pos_q    <= '0;
			sum_q    <= '0;
			prefix_q <= 1'b0;
		end else if (act.fire) begin
			unique case (act.reg_op)
				sbdo_pkg::RO_HDR: begin
					offset_q <= amount_q;
					sum_q    <= '0;
					mask_q   <= '0;
					pos_q    <= '0;
					prefix_q <= 1'b0;
					phase_q  <= sbdo_pkg::CMD_MASK1;
				end
				sbdo_pkg::RO_M1: begin
					mask_q[63:32] <= word_q;
					phase_q       <= sbdo_pkg::CMD_MASK2;
				end
				sbdo_pkg::RO_M2: begin
					mask_q[31:0] <= word_q;
					pos_q        <= '0;
					phase_q      <= sbdo_pkg::CMD_VALUE;
				end
				sbdo_pkg::RO_END: begin
					if (pos_q[sbdo_pkg::PosW-1]) begin
						phase_q <= sbdo_pkg::CMD_HEADER;
					end
				end
				default: ;
			endcase
			unique case (act.pfx_op)
				sbdo_pkg::PF_OFS_ZERO: prefix_q <= (offset_q == 32'sd0);
				sbdo_pkg::PF_AMT_EQ: begin
					if (pos_q == '0) begin
						prefix_q <= (amount_q == offset_q);
					end
				end
				default: ;
			endcase
			if (emit_val) begin
				pos_q <= pos_q + {{(sbdo_pkg::PosW-1){1'b0}}, 1'b1};
				if (prefix_q) begin
					sum_q <= res;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (act.fire && act.emit != sbdo_pkg::EM_NONE) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (act.fire && act.emit == sbdo_pkg::EM_ERR) begin
			sample    <= '0;
			position  <= '0;
			block_end <= 1'b0;
			status    <= 1'b1;
		end else if (emit_val) begin
			sample    <= res;
			position  <= pos_q[5:0];
			block_end <= (pos_q[5:0] == 6'd63);
			status    <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== hdl/sbdo_checker.sv =====
// Port-level checker for the sparse block decoder, bound to the top level.
// Depends on sparse_block_delta_offset_decoder_defines.svh.
`include "sparse_block_delta_offset_decoder_defines.svh"

module sbdo_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic [1:0]         command,
	input logic signed [31:0] amount,
	input logic [31:0]        mask_word,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [31:0] sample,
	input logic [5:0]         position,
	input logic               block_end,
	input logic               status
);

	// a stalled result holds
	`SBDO_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(sample) && $stable(position) && $stable(status), "result changed while stalled")

	// dropped requests report a blank result
	`SBDO_ASSERT_NOW(a_err_blank, out_valid && status, sample == 32'sd0 && position == 6'd0 && !block_end, "error result not blank")

	// block end only on the last position of a normal sample
	`SBDO_ASSERT_NOW(a_end_pos, out_valid && block_end, position == 6'd63 && !status, "block end at wrong position")

	// one request at a time
	`SBDO_ASSERT_NEXT(a_one_req, in_valid && in_ready, !in_ready, "request taken while busy")

endmodule

bind sparse_block_delta_offset_decoder sbdo_checker u_sbdo_checker (.*);

// ===== test/sparse_block_delta_offset_decoder_tb.sv =====
// Self-checking testbench for the sparse block delta/offset decoder.
// Predicts every decoded sample from the request stream and compares it in order.
// Depends on sbdo_pkg (token kinds) and the sparse_block_delta_offset_decoder top level.
`timescale 1ns / 1ps

module sparse_block_delta_offset_decoder_tb;

	typedef struct packed {
		logic signed [31:0] sample;
		logic [5:0]         position;
		logic               block_end;
		logic               status;
	} sample_rec_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [1:0]         command = 2'd0;
	logic signed [31:0] amount = '0;
	logic [31:0]        mask_word = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [31:0] sample;
	logic [5:0]         position;
	logic               block_end;
	logic               status;

	// random gaps on both sides unless a steady stretch is running
	bit          steady = 1'b0;
	int          fail_count = 0;
	int unsigned requests_sent = 0;

	sample_rec_t expected_samples[$];

	// decoder state as predicted
	sbdo_pkg::cmd_t     want_phase = sbdo_pkg::CMD_HEADER;
	logic signed [31:0] block_header = '0;
	logic [63:0]        block_mask = '0;
	int unsigned        next_slot = 0;
	logic signed [31:0] prefix_acc = '0;
	logic               prefix_on = 1'b0;

	sparse_block_delta_offset_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.command   (command),
		.amount    (amount),
		.mask_word (mask_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sample    (sample),
		.position  (position),
		.block_end (block_end),
		.status    (status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver back-pressure
	always @(negedge clk) begin
		out_ready <= steady ? 1'b1 : ($urandom_range(99) >= 13);
	end

	// ---------------------------------------------------------------- prediction

	function automatic logic signed [31:0] clip_add(input logic signed [31:0] a,
			input logic signed [31:0] b);
		longint total;
		total = longint'(a) + longint'(b);
		if (total > 64'sd2147483647)
			return 32'sh7FFF_FFFF;
		if (total < -64'sd2147483648)
			return 32'sh8000_0000;
		return total[31:0];
	endfunction

	function automatic bit slot_set(input int unsigned p);
		return (p < sbdo_pkg::BlockSize) && block_mask[sbdo_pkg::BlockSize - 1 - p];
	endfunction

	// decode one slot value and advance
	function automatic void push_sample(input logic signed [31:0] t);
		sample_rec_t r;
		if (prefix_on) begin
			prefix_acc = clip_add(prefix_acc, t);
			r.sample = prefix_acc;
		end else begin
			r.sample = clip_add(t, block_header);
		end
		r.position  = next_slot[5:0];
		r.block_end = (next_slot == sbdo_pkg::BlockSize - 1);
		r.status    = 1'b0;
		expected_samples.push_back(r);
		next_slot++;
	endfunction

	// absent slots up to the next present one or the end of the block
	function automatic void push_zero_run();
		while (next_slot < sbdo_pkg::BlockSize && !slot_set(next_slot))
			push_sample('0);
		if (next_slot >= sbdo_pkg::BlockSize)
			want_phase = sbdo_pkg::CMD_HEADER;
	endfunction

	function automatic void decode_request(input sbdo_pkg::cmd_t c,
			input logic signed [31:0] amt, input logic [31:0] word);
		sample_rec_t r;
		if (c != want_phase) begin
			// dropped request: one status result, state untouched
			r = '0;
			r.status = 1'b1;
			expected_samples.push_back(r);
			return;
		end
		case (c)
			sbdo_pkg::CMD_HEADER: begin
				block_header = amt;
				prefix_acc   = '0;
				block_mask   = '0;
				next_slot    = 0;
				prefix_on    = 1'b0;
				want_phase   = sbdo_pkg::CMD_MASK1;
			end
			sbdo_pkg::CMD_MASK1: begin
				block_mask = {word, 32'h0};
				want_phase = sbdo_pkg::CMD_MASK2;
			end
			sbdo_pkg::CMD_MASK2: begin
				block_mask[31:0] = word;
				next_slot  = 0;
				want_phase = sbdo_pkg::CMD_VALUE;
				if (!slot_set(0)) begin
					prefix_on = (block_header == 0);
					push_zero_run();
				end
			end
			sbdo_pkg::CMD_VALUE: begin
				if (next_slot == 0)
					prefix_on = (amt == block_header);
				push_sample(amt);
				push_zero_run();
			end
		endcase
	endfunction

	// ---------------------------------------------------------------- driving

	task automatic drive_request(input sbdo_pkg::cmd_t c, input logic signed [31:0] amt,
			input logic [31:0] word);
		@(negedge clk);
		while (!steady && $urandom_range(99) < 13) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		command   <= c;
		amount    <= amt;
		mask_word <= word;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		decode_request(c, amt, word);
		requests_sent++;
	endtask

	function automatic logic signed [31:0] pick_amount();
		case ($urandom_range(7))
			0:       return '0;
			1:       return 32'sh7FFF_FFFF;
			2:       return 32'sh8000_0000;
			3, 4:    return int'($urandom_range(2000)) - 1000;
			default: return $urandom();
		endcase
	endfunction

	// mostly sparse words so that blocks stay short
	function automatic logic [31:0] pick_mask_word();
		case ($urandom_range(19))
			0, 1:          return 32'h0;
			2:             return 32'hFFFF_FFFF;
			3, 4, 5, 6:    return 32'd1 << $urandom_range(31);
			7, 8, 9, 10, 11, 12: return $urandom() & $urandom() & $urandom();
			13, 14, 15, 16: return $urandom() & $urandom();
			default:       return $urandom();
		endcase
	endfunction

	// one well-formed block, with optional stray requests and early abort
	task automatic send_block(input int noise_pct);
		logic [63:0]        m;
		logic signed [31:0] hdr;
		logic signed [31:0] v;
		int                 kind;
		m    = {pick_mask_word(), pick_mask_word()};
		kind = $urandom_range(2);
		hdr  = (kind == 0) ? 32'sd0 : pick_amount();
		if ($urandom_range(99) < noise_pct)
			drive_request(sbdo_pkg::cmd_t'($urandom_range(3)), $urandom(), $urandom());
		drive_request(sbdo_pkg::CMD_HEADER, hdr, $urandom());
		if ($urandom_range(99) < noise_pct)
			drive_request(sbdo_pkg::cmd_t'($urandom_range(3)), $urandom(), $urandom());
		drive_request(sbdo_pkg::CMD_MASK1, $urandom(), m[63:32]);
		drive_request(sbdo_pkg::CMD_MASK2, $urandom(), m[31:0]);
		for (int p = 0; p < sbdo_pkg::BlockSize; p++) begin
			if (m[sbdo_pkg::BlockSize - 1 - p]) begin
				if ($urandom_range(99) < noise_pct / 2)
					break;
				if ($urandom_range(99) < noise_pct)
					drive_request(sbdo_pkg::cmd_t'($urandom_range(3)), $urandom(),
						$urandom());
				v = pick_amount();
				if (p == 0 && kind == 1)
					v = hdr;
				drive_request(sbdo_pkg::CMD_VALUE, v, $urandom());
			end
		end
	endtask

	// ---------------------------------------------------------------- tests

	// requests in the wrong phase are dropped with a status result
	task automatic test_out_of_order();
		drive_request(sbdo_pkg::CMD_VALUE, 32'sh7FFF_FFFF, 32'hFFFF_FFFF);
		drive_request(sbdo_pkg::CMD_MASK2, 32'sh8000_0000, 32'hFFFF_FFFF);
		drive_request(sbdo_pkg::CMD_MASK1, $urandom(), 32'h0);
		drive_request(sbdo_pkg::CMD_HEADER, 32'sd12345, $urandom());
		drive_request(sbdo_pkg::CMD_HEADER, 32'sd1, $urandom());
		drive_request(sbdo_pkg::CMD_MASK2, $urandom(), 32'h0);
		drive_request(sbdo_pkg::CMD_MASK1, $urandom(), 32'h0);
		drive_request(sbdo_pkg::CMD_VALUE, 32'sd7, $urandom());
		// empty mask with a nonzero header: all 64 slots carry the offset
		drive_request(sbdo_pkg::CMD_MASK2, $urandom(), 32'h0);
	endtask

	// empty mask with a zero header decodes as a prefix sum of zeros
	task automatic test_empty_prefix();
		drive_request(sbdo_pkg::CMD_HEADER, 32'sd0, 32'hFFFF_FFFF);
		drive_request(sbdo_pkg::CMD_MASK1, 32'sh7FFF_FFFF, 32'h0);
		drive_request(sbdo_pkg::CMD_MASK2, 32'sh8000_0000, 32'h0);
	endtask

	// header equals first sample: prefix sum that clips at the upper rail
	task automatic test_prefix_saturation();
		drive_request(sbdo_pkg::CMD_HEADER, 32'sh7FFF_FFFF, $urandom());
		drive_request(sbdo_pkg::CMD_MASK1, $urandom(), 32'h8000_0001);
		drive_request(sbdo_pkg::CMD_MASK2, $urandom(), 32'h0000_0001);
		drive_request(sbdo_pkg::CMD_VALUE, 32'sh7FFF_FFFF, $urandom());
		drive_request(sbdo_pkg::CMD_VALUE, 32'sh7FFF_FFFF, $urandom());
		drive_request(sbdo_pkg::CMD_VALUE, 32'sh8000_0000, $urandom());
	endtask

	// offset mode clipping, with slot 0 present and absent
	task automatic test_offset_saturation();
		drive_request(sbdo_pkg::CMD_HEADER, 32'sh8000_0000, $urandom());
		drive_request(sbdo_pkg::CMD_MASK1, $urandom(), 32'hC000_0000);
		drive_request(sbdo_pkg::CMD_MASK2, $urandom(), 32'h8000_0000);
		drive_request(sbdo_pkg::CMD_VALUE, -32'sd1, $urandom());
		drive_request(sbdo_pkg::CMD_VALUE, 32'sh7FFF_FFFF, $urandom());
		drive_request(sbdo_pkg::CMD_VALUE, 32'sh8000_0000, $urandom());
		drive_request(sbdo_pkg::CMD_HEADER, 32'sh7FFF_FFFF, $urandom());
		drive_request(sbdo_pkg::CMD_MASK1, $urandom(), 32'h4000_0000);
		drive_request(sbdo_pkg::CMD_MASK2, $urandom(), 32'h0);
		drive_request(sbdo_pkg::CMD_VALUE, 32'sd1, $urandom());
	endtask

	// back-to-back blocks with no gaps on either side
	task automatic test_steady_stream();
		steady = 1'b1;
		for (int b = 0; b < 8; b++)
			send_block(0);
		steady = 1'b0;
	endtask

	// random blocks with stray requests and aborted blocks mixed in
	task automatic test_random_blocks();
		while (requests_sent < 450)
			send_block(6);
	endtask

	// ---------------------------------------------------------------- checking

	always @(posedge clk) begin : check_results
		sample_rec_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_samples.size() == 0) begin
				$error("unexpected result: sample %0d position %0d status %0b",
					sample, position, status);
				fail_count++;
			end else begin
				want = expected_samples.pop_front();
				if (sample !== want.sample) begin
					$error("sample: expected %0d, got %0d", want.sample, sample);
					fail_count++;
				end
				if (position !== want.position) begin
					$error("position: expected %0d, got %0d", want.position, position);
					fail_count++;
				end
				if (block_end !== want.block_end) begin
					$error("block_end: expected %0b, got %0b", want.block_end, block_end);
					fail_count++;
				end
				if (status !== want.status) begin
					$error("status: expected %0b, got %0b", want.status, status);
					fail_count++;
				end
			end
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_out_of_order();
		test_empty_prefix();
		test_prefix_saturation();
		test_offset_saturation();
		test_steady_stream();
		test_random_blocks();

		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_samples.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (fail_count == 0 && expected_samples.size() == 0) begin
			$display("sparse_block_delta_offset_decoder_tb passed");
		end else begin
			$display("sparse_block_delta_offset_decoder_tb failed");
		end
		$finish;
	end

	// watchdog
	initial begin
		#10_000_000;
		$display("sparse_block_delta_offset_decoder_tb failed");
		$finish;
	end

endmodule
